### hdl/hashed_resource_directory_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef HASHED_RESOURCE_DIRECTORY_DEFINES_SVH
`define HASHED_RESOURCE_DIRECTORY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hrd_pkg.sv
package hrd_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [31:0] HASH_SEED  = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [15:0] VER_MAX    = 16'hFFFF;
    localparam logic [15:0] VER_FIRST  = 16'd1;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_ALLOC  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    typedef struct packed {
        logic take_byte;
        logic take_last;
        logic scan;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] start;
        logic [31:0] length;
        logic [15:0] ver;
    } entry_t;

endpackage

### hdl/hrd_ctrl.sv
module hrd_ctrl
    import hrd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd,
    output state_t  state
);

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign state    = state_reg;

    always_comb begin
        cmd.take_byte = in_ready && in_valid;
        cmd.take_last = in_ready && in_valid && in_last;
        cmd.scan      = (state_reg == ST_SCAN);
        cmd.apply     = (state_reg == ST_APPLY) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_last) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.hit || status.miss) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/hrd_datapath.sv
module hrd_datapath
    import hrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        action,
    input  logic [7:0]  name_char,
    input  logic [31:0] alloc_size,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        found,
    output logic        new_entry,
    output logic        table_full,
    output logic [5:0]  entry_index,
    output logic [31:0] data_offset,
    output logic [31:0] data_size,
    output logic [15:0] entry_version
);

    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        logic [7:0]  lc;
        logic [31:0] v;
        logic [31:0] x;
        lc = b;
        if (b inside {[8'h41:8'h5A]}) begin
            lc = b + 8'h20;
        end
        v = {{24{lc[7]}}, lc};
        x = h ^ v;
        return 32'(x * HASH_PRIME);
    endfunction

    entry_t mem [MAX_ENTRIES];

    logic [31:0]      base_reg;
    logic [31:0]      hash_reg;
    logic [31:0]      key_reg;
    logic             act_reg;
    logic [31:0]      size_reg;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      endp_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rdata_reg;
    logic             hit_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic             new_reg;
    logic             full_reg;
    logic [5:0]       idx_reg;
    logic [31:0]      off_reg;
    logic [31:0]      size_out_reg;
    logic [15:0]      ver_reg;

    logic [31:0]      hash_fold;
    logic             hit_now;
    logic             issue;
    logic             dir_full;
    logic [15:0]      ver_bump;
    logic             move;
    logic [31:0]      start_new;
    logic [31:0]      start_sel;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wdata;
    logic [31:0]      endp_next;
    logic [CNT_W-1:0] count_next;
    logic             found_next;
    logic             new_next;
    logic             full_next;
    logic [IDX_W-1:0] idx_next;
    logic [31:0]      idx_wide;
    logic             zero_fields;
    logic [31:0]      size_next;
    logic [15:0]      ver_next;

    assign hash_fold = fold_byte(hash_reg, name_char);
    assign hit_now   = rd_pend_reg && (rdata_reg.key == key_reg);
    assign issue     = cmd.scan && !hit_now && (scan_idx_reg != count_reg);
    assign dir_full  = (count_reg == CNT_W'(MAX_ENTRIES));

    assign status.hit      = hit_now;
    assign status.miss     = !rd_pend_reg && (scan_idx_reg == count_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    // update of an existing entry
    assign ver_bump  = (rdata_reg.ver == VER_MAX) ? rdata_reg.ver : rdata_reg.ver + 16'd1;
    assign move      = (size_reg == 32'd0) || (rdata_reg.length < size_reg);
    assign start_new = move ? endp_reg : rdata_reg.start;

    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        wdata       = '{key: key_reg, start: endp_reg, length: size_reg, ver: VER_FIRST};
        endp_next   = endp_reg;
        count_next  = count_reg;
        found_next  = 1'b0;
        new_next    = 1'b0;
        full_next   = 1'b0;
        idx_next    = '0;
        zero_fields = 1'b1;
        start_sel   = endp_reg;
        size_next   = size_reg;
        ver_next    = VER_FIRST;
        if (hit_reg) begin
            found_next  = 1'b1;
            idx_next    = rd_idx_reg;
            zero_fields = 1'b0;
            if (act_reg == ACT_LOOKUP) begin
                start_sel = rdata_reg.start;
                size_next = rdata_reg.length;
                ver_next  = rdata_reg.ver;
            end else begin
                wr_en     = 1'b1;
                wr_addr   = rd_idx_reg;
                wdata     = '{key: rdata_reg.key, start: start_new, length: size_reg,
                              ver: ver_bump};
                endp_next = move ? endp_reg + size_reg : endp_reg;
                start_sel = start_new;
                ver_next  = ver_bump;
            end
        end else if (act_reg == ACT_ALLOC) begin
            if (dir_full) begin
                full_next = 1'b1;
            end else begin
                wr_en       = 1'b1;
                new_next    = 1'b1;
                idx_next    = count_reg[IDX_W-1:0];
                zero_fields = 1'b0;
                endp_next   = endp_reg + size_reg;
                count_next  = count_reg + CNT_W'(1);
            end
        end
    end

    assign idx_wide = 32'(idx_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            hash_reg      <= HASH_SEED;
            count_reg     <= '0;
            endp_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (cmd.take_byte) begin
                hash_reg <= cmd.take_last ? HASH_SEED : hash_fold;
            end
            if (cmd.take_last) begin
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end else if (cmd.scan) begin
                rd_pend_reg <= issue;
                if (hit_now) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.apply) begin
                endp_reg      <= endp_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, scan pointer and result payload
    always_ff @(posedge aclk) begin
        if (cmd.take_last) begin
            key_reg      <= hash_fold;
            act_reg      <= action;
            size_reg     <= alloc_size;
            scan_idx_reg <= '0;
        end else if (issue) begin
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            rd_idx_reg   <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.apply) begin
            found_reg    <= found_next;
            new_reg      <= new_next;
            full_reg     <= full_next;
            idx_reg      <= idx_wide[5:0];
            off_reg      <= zero_fields ? 32'd0 : base_reg + start_sel;
            size_out_reg <= zero_fields ? 32'd0 : size_next;
            ver_reg      <= zero_fields ? 16'd0 : ver_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
        if (cmd.apply && wr_en) begin
            mem[wr_addr] <= wdata;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign new_entry     = new_reg;
    assign table_full    = full_reg;
    assign entry_index   = idx_reg;
    assign data_offset   = off_reg;
    assign data_size     = size_out_reg;
    assign entry_version = ver_reg;

endmodule

### hdl/hashed_resource_directory.sv
// Throughput: one name byte per cycle; the last byte starts a linear directory scan.
// The scan reads entries from index 0 up and ends on the first key match or, as a miss, at the
// entry count, with no read at all when the directory is empty; one directory read per cycle.
// No byte is taken during the scan, nor during the update step, which holds while a result waits.
// Reset: control, entry count, end pointer and data_base cleared, hash set to the seed;
// directory memory is not cleared, only entries below the entry count are ever read.
`include "hashed_resource_directory_defines.svh"

module hashed_resource_directory
    import hrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // name_char[7:0], alloc_size[39:8]
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // entry_index[5:0], data_offset[37:6], data_size[69:38], entry_version[85:70]
    output logic [87:0] m_tdata,
    output logic [2:0]  m_tuser    // found[0], new_entry[1], table_full[2]
);

    cmd_t        cmd;
    status_t     status;
    state_t      state;
    logic        found;
    logic        new_entry;
    logic        table_full;
    logic [5:0]  entry_index;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [15:0] entry_version;

    hrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    hrd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .action        (s_tuser[0]),
        .name_char     (s_tdata[7:0]),
        .alloc_size    (s_tdata[39:8]),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .found         (found),
        .new_entry     (new_entry),
        .table_full    (table_full),
        .entry_index   (entry_index),
        .data_offset   (data_offset),
        .data_size     (data_size),
        .entry_version (entry_version)
    );

    assign m_tdata = {2'b00, entry_version, data_size, data_offset, entry_index};
    assign m_tuser = {table_full, new_entry, found};

    `HRD_ASSERT_NXT(a_last_starts_scan, s_tvalid && s_tready && s_tlast, state == ST_SCAN, "last byte did not start a scan")
    `HRD_ASSERT_NXT(a_hit_ends_scan, state == ST_SCAN && status.hit, state == ST_APPLY, "scan hit did not move to update")
    `HRD_ASSERT_IMP(a_result_from_update, $rose(m_tvalid), $past(state == ST_APPLY), "result appeared outside update")

endmodule

### verif/hashed_resource_directory_tb.sv
module hashed_resource_directory_tb;
    import hrd_pkg::*;

    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic        action;
        logic [7:0]  ch;
        logic        last;
        logic [31:0] size;
    } name_byte_t;

    typedef struct packed {
        logic [31:0] len;
        logic [63:0] chars;   // byte k at [8k +: 8]
    } res_name_t;

    typedef struct packed {
        logic        found;
        logic        new_entry;
        logic        table_full;
        logic [5:0]  entry_index;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic [15:0] entry_version;
    } dir_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // name_char[7:0], alloc_size[39:8]
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = '0;     // action[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // entry_index[5:0], data_offset[37:6], data_size[69:38], entry_version[85:70]
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;          // found[0], new_entry[1], table_full[2]

    hashed_resource_directory u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    name_byte_t  pending_bytes[$];
    dir_result_t pending_results[$];
    res_name_t   name_pool[$];
    int unsigned queued_items = 0;
    int unsigned accepted_items = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Directory mirror
    logic [31:0] model_base;
    logic [31:0] hash_run;
    int unsigned dir_count;
    logic [31:0] dir_end;
    logic [31:0] dir_key[MAX_ENTRIES];
    logic [31:0] dir_start[MAX_ENTRIES];
    logic [31:0] dir_len[MAX_ENTRIES];
    logic [15:0] dir_ver[MAX_ENTRIES];

    function automatic logic [31:0] fold_name_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] v;
        v = {24'd0, b};
        if (b >= 8'h41 && b <= 8'h5A)
            v = v + 32'h20;
        // sign-extend high bytes like a signed char
        if (v[7])
            v[31:8] = '1;
        return (h ^ v) * HASH_PRIME;
    endfunction

    function automatic dir_result_t resolve_request(input logic act, input logic [31:0] key,
                                                    input logic [31:0] sz);
        dir_result_t res;
        int pos;
        res = '0;
        pos = -1;
        for (int i = 0; i < dir_count; i++)
            if (pos < 0 && dir_key[i] == key)
                pos = i;
        if (act == ACT_LOOKUP) begin
            if (pos >= 0) begin
                res.found = 1'b1;
                res.entry_index = pos[5:0];
                res.data_offset = model_base + dir_start[pos];
                res.data_size = dir_len[pos];
                res.entry_version = dir_ver[pos];
            end
        end else if (pos >= 0) begin
            if (dir_ver[pos] != VER_MAX)
                dir_ver[pos] = dir_ver[pos] + 16'd1;
            // relocate on zero size or growth
            if (sz == 32'd0 || dir_len[pos] < sz) begin
                dir_start[pos] = dir_end;
                dir_end = dir_end + sz;
            end
            dir_len[pos] = sz;
            res.found = 1'b1;
            res.entry_index = pos[5:0];
            res.data_offset = model_base + dir_start[pos];
            res.data_size = sz;
            res.entry_version = dir_ver[pos];
        end else if (dir_count >= MAX_ENTRIES) begin
            res.table_full = 1'b1;
        end else begin
            dir_key[dir_count] = key;
            dir_start[dir_count] = dir_end;
            dir_len[dir_count] = sz;
            dir_ver[dir_count] = VER_FIRST;
            res.new_entry = 1'b1;
            res.entry_index = dir_count[5:0];
            res.data_offset = model_base + dir_end;
            res.data_size = sz;
            res.entry_version = VER_FIRST;
            dir_end = dir_end + sz;
            dir_count = dir_count + 1;
        end
        return res;
    endfunction

    // Driver: hold each byte until the transaction completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_bytes[0].size, pending_bytes[0].ch};
                s_tlast <= pending_bytes[0].last;
                s_tuser <= pending_bytes[0].action;
                void'(pending_bytes.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor and prediction
    always @(posedge aclk) begin
        dir_result_t got;
        dir_result_t want;
        dir_result_t pred;
        if (!aresetn) begin
            model_base = '0;
            hash_run = HASH_SEED;
            dir_count = 0;
            dir_end = '0;
            quiet_cycles = 0;
        end else begin
            if (cfg_wr_en)
                model_base = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.found = m_tuser[0];
                got.new_entry = m_tuser[1];
                got.table_full = m_tuser[2];
                got.entry_index = m_tdata[5:0];
                got.data_offset = m_tdata[37:6];
                got.data_size = m_tdata[69:38];
                got.entry_version = m_tdata[85:70];
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: found=%0d new=%0d full=%0d idx=%0d",
                                 got.found, got.new_entry, got.table_full, got.entry_index);
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.new_entry !== want.new_entry ||
                        got.table_full !== want.table_full ||
                        got.entry_index !== want.entry_index ||
                        got.data_offset !== want.data_offset ||
                        got.data_size !== want.data_size ||
                        got.entry_version !== want.entry_version) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch exp: fnd=%0d new=%0d full=%0d idx=%0d off=%h sz=%h ver=%0d",
                                     want.found, want.new_entry, want.table_full,
                                     want.entry_index, want.data_offset, want.data_size,
                                     want.entry_version);
                            $display("         got: fnd=%0d new=%0d full=%0d idx=%0d off=%h sz=%h ver=%0d",
                                     got.found, got.new_entry, got.table_full,
                                     got.entry_index, got.data_offset, got.data_size,
                                     got.entry_version);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                accepted_items++;
                hash_run = fold_name_byte(hash_run, s_tdata[7:0]);
                if (s_tlast) begin
                    pred = resolve_request(s_tuser[0], hash_run, s_tdata[39:8]);
                    pending_results = {pending_results, pred};
                    hash_run = HASH_SEED;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge aclk);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic res_name_t make_name(input int unsigned n, input logic [63:0] chars);
        res_name_t nm;
        nm.len = n;
        nm.chars = chars;
        return nm;
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 64);
            default: return $urandom;
        endcase
    endfunction

    function automatic res_name_t random_name();
        res_name_t nm;
        logic [7:0] c;
        nm.len = ($urandom_range(0, 9) == 0) ? 32'd8 : $urandom_range(1, 4);
        nm.chars = '0;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c = 8'h61 + 8'($urandom_range(0, 25));
                4, 5, 6:    c = 8'h41 + 8'($urandom_range(0, 25));
                default:    c = 8'($urandom_range(0, 255));
            endcase
            nm.chars[8*k +: 8] = c;
        end
        return nm;
    endfunction

    // Swap letter case at random; the hash folds both cases together
    function automatic res_name_t recase_name(input res_name_t nm);
        res_name_t out;
        logic [7:0] c;
        out = nm;
        for (int k = 0; k < 8; k++) begin
            c = nm.chars[8*k +: 8];
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                $urandom_range(0, 1) == 1)
                out.chars[8*k +: 8] = c ^ 8'h20;
        end
        return out;
    endfunction

    task automatic queue_request(input logic act, input res_name_t nm, input logic [31:0] sz);
        name_byte_t it;
        for (int k = 0; k < nm.len; k++) begin
            it.ch = nm.chars[8*k +: 8];
            it.last = (k == nm.len - 1);
            // action and size only matter on the last byte; randomize the rest
            it.action = it.last ? act : 1'($urandom_range(0, 1));
            it.size = it.last ? sz : $urandom;
            pending_bytes = {pending_bytes, it};
            queued_items++;
        end
    endtask

    task automatic queue_random_phase(input int unsigned n_items);
        int unsigned target;
        res_name_t nm;
        target = queued_items + n_items;
        while (queued_items < target) begin
            if (name_pool.size() != 0 && $urandom_range(0, 99) < 55) begin
                nm = recase_name(name_pool[$urandom_range(0, name_pool.size() - 1)]);
            end else begin
                nm = random_name();
                name_pool = {name_pool, nm};
            end
            queue_request(1'($urandom_range(0, 1)), nm, pick_size());
        end
    endtask

    task automatic wait_idle();
        while (accepted_items != queued_items || pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_base(input logic [31:0] value, input int unsigned snd,
                              input int unsigned rcv);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: miss, case folding, resize rules, high and zero bytes, end wrap
        write_base(32'hFFFF_FFFF, 0, 0);
        queue_request(ACT_LOOKUP, make_name(1, 64'h61), 32'd5);
        queue_request(ACT_ALLOC,  make_name(1, 64'h41), 32'd0);
        queue_request(ACT_LOOKUP, make_name(1, 64'h61), 32'd0);
        queue_request(ACT_ALLOC,  make_name(1, 64'h61), 32'd0);
        queue_request(ACT_ALLOC,  make_name(2, 64'hFF00), 32'hFFFF_FFFF);
        queue_request(ACT_ALLOC,  make_name(1, 64'h7A), 32'h10);
        queue_request(ACT_ALLOC,  make_name(1, 64'h7A), 32'h8);
        queue_request(ACT_ALLOC,  make_name(1, 64'h5A), 32'h20);
        queue_request(ACT_LOOKUP, make_name(1, 64'h5A), 32'h0);
        queue_request(ACT_LOOKUP, make_name(2, 64'h7F80), 32'h0);
        queue_request(ACT_ALLOC,  make_name(4, 64'h5A415B40), 32'h5A5A_5A5A);
        queue_request(ACT_LOOKUP, make_name(4, 64'h7A615B40), 32'hA5A5_A5A5);
        wait_idle();

        write_base($urandom, 86, 0);
        queue_random_phase(100);
        wait_idle();

        write_base(32'h8000_0000, 0, 86);
        queue_random_phase(100);
        wait_idle();

        write_base(32'd0, 10, 10);
        queue_random_phase(100);
        wait_idle();

        // Overflow the directory with distinct names
        write_base($urandom, 0, 0);
        for (int n = 0; n < 80; n++) begin
            queue_request(ACT_ALLOC, make_name(2, {48'd0, 8'(n), 8'h7E}), pick_size());
            if (n % 8 == 0)
                queue_request(ACT_LOOKUP, make_name(2, {48'd0, 8'(n), 8'h7E}), $urandom);
        end
        wait_idle();

        write_base(32'hFFFF_FFFF, 10, 10);
        queue_random_phase(100);
        wait_idle();

        if (err_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
